// ----- design/apar_pkg.sv -----
// ----------------------------------------------------------------------------
// apar_pkg
// shared types, constants and bit-correction functions of the phase
// ambiguity resolver
// ----------------------------------------------------------------------------
package apar_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MARKER_BITS    = 32;
    localparam int DEF_POSITION_WIDTH = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int FRAME_W     = 16;
    localparam int THR_W       = 4;
    localparam int PAT_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_QPSK_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BITS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ERR_THRESH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_ROT  = 3'd4;

    localparam logic [FRAME_W-1:0] RST_FRAME_BITS = 16'd2072;
    localparam logic [THR_W-1:0]   RST_ERR_THRESH = 4'd1;
    localparam logic [PAT_W-1:0]   RST_MARKER     = 32'h1ACF_FC1D;
    localparam logic [PAT_W-1:0]   RST_MARKER_ROT = 32'h8F65_6584;

    // phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_INV  = 2'd1;
    localparam logic [1:0] PH_R90  = 2'd2;
    localparam logic [1:0] PH_R270 = 2'd3;

    // one queued result beat; pending entries are raw marker bits
    typedef struct packed {
        logic       value;
        logic [1:0] phase;
        logic       last;
        logic       pending;
        logic       odd;     // odd offset in frame
        logic       pen;     // offset marker_bits-2
        logic       fin;     // offset marker_bits-1
    } entry_t;

    // broadcast control from the top level to every queue cell
    typedef struct packed {
        logic       shift;
        logic       rel;
        logic [1:0] phase;
        logic       qpsk;
        logic       held_case;
    } cell_ctl_t;

    // marker decision unit status
    typedef struct packed {
        logic       busy;
        logic       rel;
        logic [1:0] phase;
    } dec_status_t;

    // lone bit: only an inversion applies
    function automatic logic xform_single(input logic a, input logic [1:0] ph);
        return a ^ (ph == PH_INV);
    endfunction

    // first bit of a corrected pair (a,b)
    function automatic logic xform_first(input logic a, input logic b,
                                         input logic [1:0] ph);
        logic r;
        case (ph)
            PH_NONE: r = a;
            PH_INV:  r = ~a;
            PH_R90:  r = b;
            default: r = ~b;
        endcase
        return r;
    endfunction

    // second bit of a corrected pair (a,b)
    function automatic logic xform_second(input logic a, input logic b,
                                          input logic [1:0] ph);
        logic r;
        case (ph)
            PH_NONE: r = b;
            PH_INV:  r = ~b;
            PH_R90:  r = ~a;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

// ----- design/apar_cell.sv -----
// ----------------------------------------------------------------------------
// apar_cell
// one slot of the shifting result queue; corrects its own marker bit in
// place when the phase decision is broadcast
// ----------------------------------------------------------------------------
module apar_cell import apar_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      wr_en,
    input  entry_t    wr_entry,
    input  entry_t    up_fwd,
    input  logic      head_nb_value,
    input  logic      tail_nb_value,
    output entry_t    entry,
    output entry_t    fwd
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t xf;

    // in-place correction of a pending marker bit
    // a final marker bit stands alone only at an even offset (odd marker)
    always_comb
    begin
        xf = entry_reg;
        if (ctl.rel && entry_reg.pending)
        begin
            xf.pending = 1'b0;
            xf.phase   = ctl.phase;
            xf.last    = entry_reg.fin | (entry_reg.pen & ctl.held_case);
            if (!ctl.qpsk || (entry_reg.fin && !entry_reg.odd))
                xf.value = xform_single(entry_reg.value, ctl.phase);
            else if (entry_reg.odd)
                xf.value = xform_second(head_nb_value, entry_reg.value, ctl.phase);
            else
                xf.value = xform_first(entry_reg.value, tail_nb_value, ctl.phase);
        end
    end

    always_comb
    begin
        if (wr_en)
            entry_next = wr_entry;
        else if (ctl.shift)
            entry_next = up_fwd;
        else
            entry_next = xf;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign fwd   = xf;

endmodule

// ----- design/apar_decide.sv -----
// ----------------------------------------------------------------------------
// apar_decide
// marker buffer, two-stage match count against both patterns and the
// phase decision
// ----------------------------------------------------------------------------
module apar_decide import apar_pkg::*;
#(
    parameter int MARKER_BITS = DEF_MARKER_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mk_shift,
    input  logic             mk_start,
    input  logic             in_bit,
    input  logic             qpsk,
    input  logic [THR_W-1:0] threshold,
    input  logic [PAT_W-1:0] pattern,
    input  logic [PAT_W-1:0] pattern_rot,
    output dec_status_t      status
);

    localparam int NG   = (MARKER_BITS + 7) / 8;
    localparam int PADW = NG * 8;
    localparam int CW   = $clog2(MARKER_BITS + 1);
    localparam int TW   = $clog2(MARKER_BITS + 16) + 1;
    localparam logic [TW-1:0] MB_T = TW'(MARKER_BITS);

    logic [MARKER_BITS-1:0] mbuf_reg;
    logic [MARKER_BITS-1:0] mbuf_next;
    logic                   s1_reg;
    logic                   s2_reg;
    logic                   rel_reg;
    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;

    logic [PADW-1:0] diff0;
    logic [PADW-1:0] diff1;
    logic [3:0]      grp0_c   [NG];
    logic [3:0]      grp1_c   [NG];
    logic [3:0]      grp0_reg [NG];
    logic [3:0]      grp1_reg [NG];
    logic [CW-1:0]   mis0;
    logic [CW-1:0]   mis1;
    logic [TW-1:0]   m0_t;
    logic [TW-1:0]   m1_t;
    logic [TW-1:0]   thr_t;

    assign mbuf_next = {mbuf_reg[MARKER_BITS-2:0], in_bit};

    // stage one: mismatch counts per byte group
    always_comb
    begin
        diff0 = PADW'(mbuf_reg ^ MARKER_BITS'(pattern));
        diff1 = PADW'(mbuf_reg ^ MARKER_BITS'(pattern_rot));
        for (int g = 0; g < NG; g++)
        begin
            grp0_c[g] = '0;
            grp1_c[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                grp0_c[g] = grp0_c[g] + 4'(diff0[g*8+b]);
                grp1_c[g] = grp1_c[g] + 4'(diff1[g*8+b]);
            end
        end
    end

    // stage two: totals and the ordered tests, later ones win
    always_comb
    begin
        mis0 = '0;
        mis1 = '0;
        for (int g = 0; g < NG; g++)
        begin
            mis0 = mis0 + CW'(grp0_reg[g]);
            mis1 = mis1 + CW'(grp1_reg[g]);
        end
        m0_t  = TW'(mis0);
        m1_t  = TW'(mis1);
        thr_t = TW'(threshold);
        phase_next = phase_reg;
        if (m0_t <= thr_t)
            phase_next = PH_NONE;
        if (m0_t + thr_t >= MB_T)
            phase_next = PH_INV;
        if (qpsk)
        begin
            if (m1_t <= thr_t)
                phase_next = PH_R90;
            if (m1_t + thr_t >= MB_T)
                phase_next = PH_R270;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbuf_reg  <= '0;
            s1_reg    <= 1'b0;
            s2_reg    <= 1'b0;
            rel_reg   <= 1'b0;
            phase_reg <= PH_NONE;
        end
        else
        begin
            if (mk_shift)
                mbuf_reg <= mbuf_next;
            s1_reg  <= mk_start;
            s2_reg  <= s1_reg;
            rel_reg <= s2_reg;
            if (s2_reg)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg)
        begin
            grp0_reg <= grp0_c;
            grp1_reg <= grp1_c;
        end
    end

    assign status.busy  = s1_reg | s2_reg;
    assign status.rel   = rel_reg;
    assign status.phase = phase_reg;

endmodule

// ----- design/asm_phase_ambiguity_resolver_top.sv -----
// ----------------------------------------------------------------------------
// asm_phase_ambiguity_resolver_top
// resolves the psk phase ambiguity of framed hard bits from the sync marker
// at the head of each frame and emits every frame phase-corrected
// ----------------------------------------------------------------------------
// throughput: one input bit per cycle when not stalled; the input stalls after
//   each frame's final marker bit while the match counts settle (two-stage
//   count pipeline) and while the result queue is near full
// ordering: payload bits show in the cycle after acceptance, behind any queued
//   beats; the marker burst follows the decision through the s1, s2 and release registers
// reset: asynchronous, active low; position, phase, held bit, marker buffer
//   and queue fill clear, registers take their defaults
// ----------------------------------------------------------------------------
module asm_phase_ambiguity_resolver_top import apar_pkg::*;
#(
    parameter int MARKER_BITS    = DEF_MARKER_BITS,
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input bit stream
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   in_bit,
    // corrected result stream
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   out_bit,
    output logic [1:0]             phase_code,
    output logic                   last_of_run
);

    // queue holds a whole marker plus room for a pair beat and slack
    localparam int DEPTH = MARKER_BITS + 4;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = ((POSITION_WIDTH > FRAME_W) ? POSITION_WIDTH : FRAME_W) + 1;
    localparam logic [EW-1:0] MB_E   = EW'(MARKER_BITS);
    localparam logic [EW-1:0] CAP_E  = EW'({1'b1, {POSITION_WIDTH{1'b0}}});
    localparam logic          MB_ODD = ((MARKER_BITS % 2) == 1);
    localparam logic [CNT_W-1:0] FULL_MARK = CNT_W'(DEPTH - 2);

    // configuration registers
    logic               qpsk_reg;
    logic [FRAME_W-1:0] frame_bits_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [PAT_W-1:0]   pat_reg;
    logic [PAT_W-1:0]   rot_reg;

    // frame tracking
    logic [POSITION_WIDTH-1:0] pos_reg;
    logic [POSITION_WIDTH-1:0] pos_next;
    logic                      held_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic [EW-1:0] eff_lo;
    logic [EW-1:0] eff;
    logic [EW-1:0] pos_e;
    logic          at_end;
    logic          in_marker;
    logic          marker_last;
    logic          held_case;

    logic          in_accept;
    logic          pop;
    logic          push0;
    logic          push1;
    logic          hold_bit;
    entry_t        e0;
    entry_t        e1;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] base_p1;

    dec_status_t dec_status;
    cell_ctl_t   ctl;

    entry_t cell_q [DEPTH];
    entry_t cell_f [DEPTH];

    // ------------------------------------------------------------------------
    // configuration port, out-of-range indexes are ignored
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpsk_reg       <= 1'b0;
            frame_bits_reg <= RST_FRAME_BITS;
            thr_reg        <= RST_ERR_THRESH;
            pat_reg        <= RST_MARKER;
            rot_reg        <= RST_MARKER_ROT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QPSK_MODE:  qpsk_reg       <= cfg_data[0];
                REG_FRAME_BITS: frame_bits_reg <= cfg_data[FRAME_W-1:0];
                REG_ERR_THRESH: thr_reg        <= cfg_data[THR_W-1:0];
                REG_MARKER:     pat_reg        <= cfg_data[PAT_W-1:0];
                REG_MARKER_ROT: rot_reg        <= cfg_data[PAT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // frame length: short frames stretch to the marker, long ones cap at the
    // position counter range
    // ------------------------------------------------------------------------
    always_comb
    begin
        eff_lo = (EW'(frame_bits_reg) < MB_E) ? MB_E : EW'(frame_bits_reg);
        eff    = (eff_lo > CAP_E) ? CAP_E : eff_lo;
    end

    assign pos_e       = EW'(pos_reg);
    assign at_end      = (pos_e + EW'(1)) >= eff;
    assign in_marker   = pos_e < MB_E;
    assign marker_last = pos_e == (MB_E - EW'(1));
    // qpsk with an odd marker: the final marker bit opens a pair with the
    // first payload bit, so it is held back and not queued
    assign held_case   = qpsk_reg & MB_ODD & (MB_E < eff);

    assign pos_next = at_end ? '0 : pos_reg + POSITION_WIDTH'(1);

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    assign in_stall  = dec_status.busy | (count_reg > FULL_MARK);
    assign in_accept = in_valid & ~in_stall;
    assign out_valid = (count_reg != '0) & ~cell_q[0].pending;
    assign pop       = out_valid & ~out_stall;

    // ------------------------------------------------------------------------
    // result beats for the accepted bit
    // marker bits go in raw and pending, payload bits go in corrected
    // ------------------------------------------------------------------------
    always_comb
    begin
        e0       = '0;
        e1       = '0;
        push0    = 1'b0;
        push1    = 1'b0;
        hold_bit = 1'b0;
        if (in_marker)
        begin
            if (marker_last && held_case)
                hold_bit = 1'b1;
            else
            begin
                e0.value   = in_bit;
                e0.pending = 1'b1;
                e0.odd     = pos_reg[0];
                e0.pen     = pos_e == (MB_E - EW'(2));
                e0.fin     = marker_last;
                push0      = 1'b1;
            end
        end
        else if (!qpsk_reg)
        begin
            e0.value = xform_single(in_bit, dec_status.phase);
            e0.phase = dec_status.phase;
            e0.last  = 1'b1;
            push0    = 1'b1;
        end
        else if (!pos_reg[0])
        begin
            // lone last bit of an odd frame goes out alone
            if (at_end)
            begin
                e0.value = xform_single(in_bit, dec_status.phase);
                e0.phase = dec_status.phase;
                e0.last  = 1'b1;
                push0    = 1'b1;
            end
            else
                hold_bit = 1'b1;
        end
        else
        begin
            e0.value = xform_first(held_reg, in_bit, dec_status.phase);
            e0.phase = dec_status.phase;
            e1.value = xform_second(held_reg, in_bit, dec_status.phase);
            e1.phase = dec_status.phase;
            e1.last  = 1'b1;
            push0    = 1'b1;
            push1    = 1'b1;
        end
    end

    // first free slot after this cycle's pop
    assign base    = count_reg - CNT_W'(pop);
    assign base_p1 = base + CNT_W'(1);

    always_comb
    begin
        count_next = base;
        if (in_accept)
            count_next = base + CNT_W'(push0) + CNT_W'(push1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            held_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_accept)
            begin
                pos_reg <= pos_next;
                if (hold_bit)
                    held_reg <= in_bit;
            end
        end
    end

    // ------------------------------------------------------------------------
    // marker match count and phase decision
    // ------------------------------------------------------------------------
    apar_decide #(
        .MARKER_BITS (MARKER_BITS)
    ) u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .mk_shift    (in_accept & in_marker),
        .mk_start    (in_accept & marker_last),
        .in_bit      (in_bit),
        .qpsk        (qpsk_reg),
        .threshold   (thr_reg),
        .pattern     (pat_reg),
        .pattern_rot (rot_reg),
        .status      (dec_status)
    );

    // ------------------------------------------------------------------------
    // result queue: a row of cells shifting toward cell 0 on every popped
    // beat; the decision releases the pending marker bits in place, each
    // pair partner sitting in the neighboring cell
    // ------------------------------------------------------------------------
    assign ctl.shift     = pop;
    assign ctl.rel       = dec_status.rel;
    assign ctl.phase     = dec_status.phase;
    assign ctl.qpsk      = qpsk_reg;
    assign ctl.held_case = held_case;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t up_fwd;
        logic   head_nb;
        logic   tail_nb;
        logic   wr0;
        logic   wr1;

        if (i == DEPTH - 1)
        begin : g_tail
            assign up_fwd  = '0;
            assign tail_nb = 1'b0;
        end
        else
        begin : g_mid
            assign up_fwd  = cell_f[i+1];
            assign tail_nb = cell_q[i+1].value;
        end

        if (i == 0)
        begin : g_head
            assign head_nb = 1'b0;
        end
        else
        begin : g_body
            assign head_nb = cell_q[i-1].value;
        end

        assign wr0 = in_accept & push0 & (base == CNT_W'(i));
        assign wr1 = in_accept & push1 & (base_p1 == CNT_W'(i));

        apar_cell u_cell (
            .clk           (clk),
            .ctl           (ctl),
            .wr_en         (wr0 | wr1),
            .wr_entry      (wr1 ? e1 : e0),
            .up_fwd        (up_fwd),
            .head_nb_value (head_nb),
            .tail_nb_value (tail_nb),
            .entry         (cell_q[i]),
            .fwd           (cell_f[i])
        );
    end

    // head of the queue drives the result beat
    assign out_bit     = cell_q[0].value;
    assign phase_code  = cell_q[0].phase;
    assign last_of_run = cell_q[0].last;

endmodule

// ----- tb/asm_phase_ambiguity_resolver_top_tb.sv -----
// ----------------------------------------------------------------------------
// asm_phase_ambiguity_resolver_top_tb
// self-checking bench for the sync-marker phase ambiguity resolver: a bit-true
// predictor follows every accepted input bit and a monitor compares each
// corrected beat with the oldest predicted one, under random gaps and stalls
// ----------------------------------------------------------------------------
module asm_phase_ambiguity_resolver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apar_pkg::*;

    localparam int MARKER_BITS  = DEF_MARKER_BITS;
    localparam int HALF_PERIOD  = 10;
    // quiet cycles waited after the last awaited beat so that the block is left idle
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 300000;

    // one corrected beat as it leaves the block
    typedef struct packed {
        logic       corr_bit;
        logic [1:0] phase;
        logic       last;
    } beat_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic                   in_bit      = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic                   out_bit;
    logic [1:0]             phase_code;
    logic                   last_of_run;

    // predicted beats not yet seen, oldest first
    beat_t corrected_beats[$];
    // beats caused by the bit being predicted
    beat_t burst[$];
    beat_t want_beat;

    // predictor copy of the registers
    logic             m_qpsk;
    logic [15:0]      m_frame_bits;
    logic [3:0]       m_thresh;
    logic [31:0]      m_marker;
    logic [31:0]      m_marker_rot;

    // predictor copy of the state
    logic [MARKER_BITS-1:0] mk_buf;
    int                     frame_pos;
    logic [1:0]             cur_phase;
    logic                   held_bit;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int markers_seen  = 0;
    int cycle_count   = 0;

    asm_phase_ambiguity_resolver_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_bit      (in_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_bit     (out_bit),
        .phase_code  (phase_code),
        .last_of_run (last_of_run)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: run limit reached, %0d beats still awaited", $time,
                     corrected_beats.size());
            $display("FAIL asm_phase_ambiguity_resolver_top");
            $finish;
        end
    end

    // receiver: random stall and beat check against the oldest prediction
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (corrected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: beat with nothing awaited: bit %0b phase %0d last %0b",
                         $time, out_bit, phase_code, last_of_run);
            end
            else
            begin
                want_beat = corrected_beats.pop_front();
                beats_checked++;
                if (out_bit !== want_beat.corr_bit)
                begin
                    errors++;
                    $display("%0t: out_bit expected %0b actual %0b", $time,
                             want_beat.corr_bit, out_bit);
                end
                if (phase_code !== want_beat.phase)
                begin
                    errors++;
                    $display("%0t: phase_code expected %0d actual %0d", $time,
                             want_beat.phase, phase_code);
                end
                if (last_of_run !== want_beat.last)
                begin
                    errors++;
                    $display("%0t: last_of_run expected %0b actual %0b", $time,
                             want_beat.last, last_of_run);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // frame length in force; anything shorter than the marker is the marker
    function automatic int frame_len();
        return (m_frame_bits < MARKER_BITS) ? MARKER_BITS : int'(m_frame_bits);
    endfunction

    function automatic int match_count(input logic [MARKER_BITS-1:0] pat);
        logic [MARKER_BITS-1:0] diff;
        int                     n;
        diff = mk_buf ^ pat;
        n = MARKER_BITS;
        for (int i = 0; i < MARKER_BITS; i++)
            if (diff[i])
                n--;
        return n;
    endfunction

    // later tests override earlier ones, no hit keeps the old phase
    function automatic void pick_phase();
        int t;
        int m;
        int r;
        t = m_thresh;
        m = match_count(m_marker);
        if (m >= MARKER_BITS - t)
            cur_phase = PH_NONE;
        if (m <= t)
            cur_phase = PH_INV;
        if (m_qpsk)
        begin
            r = match_count(m_marker_rot);
            if (r >= MARKER_BITS - t)
                cur_phase = PH_R90;
            if (r <= t)
                cur_phase = PH_R270;
        end
    endfunction

    // a lone bit only ever sees an inversion
    function automatic void lone_beat(input logic a);
        beat_t nb;
        nb.corr_bit = (cur_phase == PH_INV) ? ~a : a;
        nb.phase    = cur_phase;
        nb.last     = 1'b0;
        burst.push_back(nb);
    endfunction

    function automatic void pair_beats(input logic a, input logic b);
        beat_t nx;
        beat_t ny;
        case (cur_phase)
            PH_INV:
            begin
                nx.corr_bit = ~a;
                ny.corr_bit = ~b;
            end
            PH_R90:
            begin
                nx.corr_bit = b;
                ny.corr_bit = ~a;
            end
            PH_R270:
            begin
                nx.corr_bit = ~b;
                ny.corr_bit = a;
            end
            default:
            begin
                nx.corr_bit = a;
                ny.corr_bit = b;
            end
        endcase
        nx.phase = cur_phase;
        ny.phase = cur_phase;
        nx.last  = 1'b0;
        ny.last  = 1'b0;
        burst.push_back(nx);
        burst.push_back(ny);
    endfunction

    // advance the predictor by one accepted input bit
    function automatic void resolve_bit(input logic b);
        int    eff;
        int    p;
        beat_t nb;
        eff = frame_len();
        p = frame_pos;
        burst.delete();
        if (p < MARKER_BITS)
        begin
            mk_buf = {mk_buf[MARKER_BITS-2:0], b};
            if (p == MARKER_BITS - 1)
            begin
                markers_seen++;
                pick_phase();
                for (int k = 0; k < MARKER_BITS; k++)
                begin
                    if (!m_qpsk)
                        lone_beat(mk_buf[MARKER_BITS-1-k]);
                    else
                    begin
                        pair_beats(mk_buf[MARKER_BITS-1-k], mk_buf[MARKER_BITS-2-k]);
                        k++;
                    end
                end
            end
        end
        else if (!m_qpsk)
            lone_beat(b);
        else if (p % 2 == 0)
        begin
            // odd-length frame: its final bit has no partner
            if (p + 1 >= eff)
                lone_beat(b);
            else
                held_bit = b;
        end
        else
            pair_beats(held_bit, b);
        frame_pos = (p + 1 >= eff) ? 0 : p + 1;
        foreach (burst[i])
        begin
            nb = burst[i];
            nb.last = (i == burst.size() - 1);
            corrected_beats.push_back(nb);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input beat; valid stays high into the next call unless a gap is drawn
    task automatic send_bit(input logic b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_bit   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        resolve_bit(b);
        items_sent++;
    endtask

    task automatic send_marker(input logic [31:0] w);
        for (int i = MARKER_BITS - 1; i >= 0; i--)
            send_bit(w[i]);
    endtask

    task automatic send_payload(input int n);
        repeat (n)
            send_bit(1'($urandom_range(1)));
    endtask

    // fill out a frame left open so the next marker lands at offset zero
    task automatic align_frame();
        while (frame_pos != 0)
            send_bit(1'($urandom_range(1)));
    endtask

    // first n bits of a frame that starts with marker w
    task automatic send_partial(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++)
            send_bit((i < MARKER_BITS) ? w[MARKER_BITS-1-i] : 1'($urandom_range(1)));
    endtask

    task automatic send_frame(input logic [31:0] w);
        align_frame();
        send_partial(w, frame_len());
    endtask

    // hold the input until every awaited beat is out and the block is quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (corrected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // one register write; the enable drops before the task returns, keeping the writes apart
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_QPSK_MODE:  m_qpsk       = data[0];
            REG_FRAME_BITS: m_frame_bits = data[15:0];
            REG_ERR_THRESH: m_thresh     = data[3:0];
            REG_MARKER:     m_marker     = data[31:0];
            REG_MARKER_ROT: m_marker_rot = data[31:0];
            default:        ;
        endcase
    endtask

    // all five registers, idle block only; junk fills unused upper data bits
    task automatic set_config(input logic q, input logic [15:0] fb, input logic [3:0] thr,
                              input logic [31:0] pat, input logic [31:0] rot,
                              input bit junk);
        logic [31:0] fill;
        wait_drained();
        fill = junk ? $urandom : 32'h0;
        write_reg(REG_QPSK_MODE, {fill[31:1], q});
        write_reg(REG_FRAME_BITS, {fill[31:16], fb});
        write_reg(REG_ERR_THRESH, {fill[31:4], thr});
        write_reg(REG_MARKER, pat);
        write_reg(REG_MARKER_ROT, rot);
    endtask

    // flip n distinct bits of w
    function automatic logic [31:0] flip_bits(input logic [31:0] w, input int n);
        logic [31:0] mask;
        int          done;
        int          k;
        mask = '0;
        done = 0;
        while (done < n)
        begin
            k = $urandom_range(MARKER_BITS - 1);
            if (!mask[k])
            begin
                mask[k] = 1'b1;
                done++;
            end
        end
        return w ^ mask;
    endfunction

    // mostly a real marker in some phase with a few bit errors, else noise
    function automatic logic [31:0] random_marker();
        logic [31:0] base;
        int          cap;
        if ($urandom_range(99) < 15)
            return $urandom;
        case ($urandom_range(m_qpsk ? 3 : 1))
            0:       base = m_marker;
            1:       base = ~m_marker;
            2:       base = m_marker_rot;
            default: base = ~m_marker_rot;
        endcase
        cap = int'(m_thresh) + 2;
        return flip_bits(base, $urandom_range(cap));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: default marker in bpsk, then a shortened frame
    task automatic test_defaults();
        idle_pct  = 0;
        stall_pct = 0;
        send_marker(RST_MARKER);
        send_payload(4);
        set_config(1'b0, 16'd32, RST_ERR_THRESH, RST_MARKER, RST_MARKER_ROT, 1'b0);
        // position is past the new length, so the frame closes on the next beat
        align_frame();
    endtask

    // bpsk decisions right at the threshold edges, with all-zero and all-one
    // markers; a zero frame length stretches to the marker
    task automatic test_bpsk_thresholds();
        set_config(1'b0, 16'd0, 4'd0, 32'h0000_0000, $urandom, 1'b0);
        send_frame(~m_marker);
        // one error under a zero threshold: no decision, inversion stays
        send_frame(flip_bits(m_marker, 1));
        set_config(1'b0, 16'd0, 4'd15, 32'hFFFF_FFFF, $urandom, 1'b0);
        send_frame(flip_bits(m_marker, 15));
    endtask

    // qpsk rotations on marker-only frames, and a rotation code carried into
    // bpsk unchanged
    task automatic test_qpsk_phases();
        stall_pct = 23;
        set_config(1'b1, 16'd32, 4'd2, RST_MARKER, RST_MARKER_ROT, 1'b0);
        send_frame(~m_marker_rot);
        send_frame(m_marker_rot);
        set_config(1'b0, 16'd32, 4'd2, RST_MARKER, RST_MARKER_ROT, 1'b0);
        send_frame(flip_bits(m_marker, 8));
        stall_pct = 0;
    endtask

    // odd qpsk frame and the longest length
    task automatic test_frame_lengths();
        set_config(1'b1, 16'd33, 4'd1, RST_MARKER, RST_MARKER_ROT, 1'b0);
        send_frame(~m_marker);
        set_config(1'b0, 16'hFFFF, 4'd1, RST_MARKER, RST_MARKER_ROT, 1'b0);
        send_marker(~m_marker);
        send_payload(2);
        wait_drained();
        write_reg(REG_FRAME_BITS, 32'd34);
        align_frame();
    endtask

    // mode and length changed inside a frame, patterns changed inside a marker
    task automatic test_mid_frame_changes();
        set_config(1'b1, 16'd40, 4'd3, RST_MARKER, RST_MARKER_ROT, 1'b0);
        send_marker(m_marker_rot);
        // held bit from the third payload beat stays behind
        send_payload(3);
        wait_drained();
        write_reg(REG_QPSK_MODE, 32'd0);
        send_payload(2);
        wait_drained();
        // odd offset now pairs with the stale held bit
        write_reg(REG_QPSK_MODE, 32'd1);
        send_payload(1);
        align_frame();
        send_partial(~m_marker, 16);
        wait_drained();
        write_reg(REG_ERR_THRESH, 32'd0);
        write_reg(REG_MARKER, 32'hDEAD_BEEF);
        send_bit(1'b0);
        send_payload(15);
        send_payload(4);
        wait_drained();
        // shrink the frame below the current offset
        write_reg(REG_FRAME_BITS, 32'd34);
        align_frame();
        send_frame(m_marker);
    endtask

    // writes to indexes past the last register leave everything alone
    task automatic test_bad_index();
        set_config(1'b0, 16'd32, 4'd1, $urandom, $urandom, 1'b0);
        for (int i = REG_MARKER_ROT + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), (i % 2 == 0) ? 32'hFFFF_FFFF : $urandom);
        send_frame(~m_marker);
    endtask

    // random settings and frames under each gap and stall mix
    task automatic test_random();
        int idle_mix[4];
        int stall_mix[4];
        int start;
        idle_mix  = '{0, 61, 0, 23};
        stall_mix = '{0, 0, 61, 23};
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            start = items_sent;
            while (items_sent - start < 30)
            begin
                set_config($urandom_range(1),
                           ($urandom_range(9) == 0) ? 16'($urandom_range(33))
                                                    : 16'($urandom_range(34, 38)),
                           4'($urandom_range(15)),
                           $urandom_range(1) ? RST_MARKER : 32'($urandom),
                           $urandom_range(1) ? RST_MARKER_ROT : 32'($urandom),
                           1'b1);
                if ($urandom_range(9) == 0)
                begin
                    // broken frame: the next setting lands mid-frame
                    align_frame();
                    send_partial(random_marker(), $urandom_range(1, frame_len() - 1));
                end
                else
                    send_frame(random_marker());
                // sender holds off until the block has emptied
                if ($urandom_range(3) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        m_qpsk       = 1'b0;
        m_frame_bits = RST_FRAME_BITS;
        m_thresh     = RST_ERR_THRESH;
        m_marker     = RST_MARKER;
        m_marker_rot = RST_MARKER_ROT;
        mk_buf       = '0;
        frame_pos    = 0;
        cur_phase    = PH_NONE;
        held_bit     = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_bpsk_thresholds();
        test_qpsk_phases();
        test_frame_lengths();
        test_mid_frame_changes();
        test_bad_index();
        test_random();

        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();

        $display("sent %0d input bits holding %0d markers, checked %0d corrected beats",
                 items_sent, markers_seen, beats_checked);
        $display("bpsk and qpsk, all phase codes, odd, short and longest frames, "
                 , "mid-frame changes, gaps and stalls");
        if (errors == 0)
            $display("PASS asm_phase_ambiguity_resolver_top");
        else
            $display("FAIL asm_phase_ambiguity_resolver_top");
        $finish;
    end

endmodule
